FILE: rtl/rsmq_pkg.sv
// Package with shared types and constants for the mod-q rejection sampler.
package rsmq_pkg;

  localparam int unsigned CandNum   = 6;   // two candidates per 3-byte group, three groups
  localparam int unsigned CoefW     = 12;
  localparam int unsigned ModW      = 13;
  localparam int unsigned IdxW      = 8;
  localparam int unsigned BlkW      = 64;
  localparam int unsigned StreamW   = 80;  // up to two leftover bytes plus one block
  localparam logic [ModW-1:0] ModResetVal = 13'd3329;

  typedef logic [CoefW-1:0] coef_t;
  typedef coef_t [CandNum-1:0] cand_arr_t;
  typedef logic [CandNum-1:0] cand_mask_t;

  // Result of unpacking one block against the current leftover bytes.
  typedef struct packed {
    cand_arr_t  cand;
    cand_mask_t ok;        // candidate present and below modulus
    logic [15:0] lo_bytes; // bytes carried to the next block, earlier byte low
    logic [1:0]  lo_cnt;
  } unpack_t;

endpackage

FILE: rtl/rsmq_unpack.sv
// Byte-stream assembly, 12-bit candidate extraction and modulus compare.
module rsmq_unpack
  import rsmq_pkg::*;
(
  input  logic [BlkW-1:0] blk_i,
  input  logic [15:0]     lo_bytes_i,
  input  logic [1:0]      lo_cnt_i,
  input  logic [ModW-1:0] modulus_i,
  output unpack_t         res_o
);

  logic [BlkW-1:0]    rev;
  logic [StreamW-1:0] stream;
  logic [2:0]         grp_ok;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      rev[8*k +: 8] = blk_i[8*(7-k) +: 8];
    end
  end

  always_comb begin
    case (lo_cnt_i)
      2'd0: begin
        stream      = {16'd0, rev};
        grp_ok      = 3'b011;
        res_o.lo_bytes = stream[63:48];
        res_o.lo_cnt   = 2'd2;
      end
      2'd1: begin
        stream      = {8'd0, rev, lo_bytes_i[7:0]};
        grp_ok      = 3'b111;
        res_o.lo_bytes = 16'd0;
        res_o.lo_cnt   = 2'd0;
      end
      default: begin
        // three leftover bytes cannot occur; treated as two
        stream      = {rev, lo_bytes_i};
        grp_ok      = 3'b111;
        res_o.lo_bytes = {8'd0, stream[79:72]};
        res_o.lo_cnt   = 2'd1;
      end
    endcase
    for (int g = 0; g < 3; g++) begin
      res_o.cand[2*g]   = stream[24*g +: 12];
      res_o.cand[2*g+1] = stream[24*g+12 +: 12];
      res_o.ok[2*g]     = grp_ok[g] && ({1'b0, stream[24*g +: 12]} < modulus_i);
      res_o.ok[2*g+1]   = grp_ok[g] && ({1'b0, stream[24*g+12 +: 12]} < modulus_i);
    end
  end

endmodule

FILE: rtl/rejection_sampler_mod_q.sv
// Top level of the 12-bit uniform rejection sampler modulo q.
//
// Input stream: each request carries one 8-byte XOF block in tdata and the
// first_of_poly / first_of_buffer flags in tuser. The block is byte reversed,
// joined to the leftover bytes, cut into 3-byte groups and split into 12-bit
// candidates; those below the modulus leave as coefficients, one per request
// on the output stream, with the polynomial index in tdata and tlast on
// coefficient NUM_COEFFS-1. Once a polynomial is complete, blocks are taken
// and dropped until one arrives with first_of_poly set.
// A taken block's candidates are registered in the six-entry candidate
// buffer; its accepted coefficients then move to the output register, which
// drains one coefficient a cycle while the output is not stalled. The next
// block is taken in the cycle its predecessor's last coefficient moves to
// the output register. A stall on the output holds the output register and
// the pending candidates; s_axis_tready_o stays low until the last of them
// moves out. Reset empties both stages, clears the count and leftover bytes,
// and sets the modulus to 3329.
module rejection_sampler_mod_q
  import rsmq_pkg::*;
#(
  parameter int unsigned NUM_COEFFS = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [ModW-1:0] cfg_wdata_i,     // modulus
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [BlkW-1:0] s_axis_tdata_i,  // [63:0] xof_block
  input  logic [1:0]      s_axis_tuser_i,  // [0] first_of_poly, [1] first_of_buffer
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [23:0]     m_axis_tdata_o,  // [11:0] coefficient, [19:12] coeff_index, 0
  output logic            m_axis_tlast_o   // last_coeff
);

  localparam int unsigned CntW = $clog2(NUM_COEFFS + 1);
  localparam logic [CntW:0] NumC = (CntW+1)'(NUM_COEFFS);

  logic [ModW-1:0] modulus_q;
  logic [15:0]     lo_bytes_q, lo_bytes_d;
  logic [1:0]      lo_cnt_q, lo_cnt_d;
  logic [CntW-1:0] cnt_q, cnt_d;          // count after all taken blocks
  cand_arr_t       cand_q;
  cand_mask_t      mask_q, mask_d, mask_pop;
  logic [CntW-1:0] ecnt_q, ecnt_d;        // index of next coefficient to leave
  logic            ovalid_q;
  coef_t           ocoef_q;
  logic [IdxW-1:0] oidx_q;
  logic            olast_q;

  logic            in_acc, load_out;
  logic [15:0]     lo_in;
  logic [1:0]      lo_cnt_in;
  logic [CntW-1:0] base;
  unpack_t         up;
  logic [2:0]      n_ok;
  logic [CntW:0]   sum;
  logic            full;
  logic [2:0]      sel;
  logic            is_last;

  // Flags clear state before the block is used.
  always_comb begin
    base      = s_axis_tuser_i[0] ? '0 : cnt_q;
    lo_in     = (s_axis_tuser_i[0] || s_axis_tuser_i[1]) ? 16'd0 : lo_bytes_q;
    lo_cnt_in = (s_axis_tuser_i[0] || s_axis_tuser_i[1]) ? 2'd0 : lo_cnt_q;
  end

  rsmq_unpack u_unpack (
    .blk_i      (s_axis_tdata_i),
    .lo_bytes_i (lo_in),
    .lo_cnt_i   (lo_cnt_in),
    .modulus_i  (modulus_q),
    .res_o      (up)
  );

  always_comb begin
    n_ok = '0;
    for (int i = 0; i < CandNum; i++) begin
      n_ok = n_ok + 3'(up.ok[i]);
    end
    sum  = {1'b0, base} + (CntW+1)'(n_ok);
    full = ({1'b0, base} >= NumC);
  end

  // Lowest pending candidate goes out next.
  always_comb begin
    sel = '0;
    for (int i = CandNum - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = 3'(i);
      end
    end
    is_last = ({1'b0, ecnt_q} + (CntW+1)'(1)) == NumC;
  end

  assign load_out = (mask_q != '0) && (!ovalid_q || m_axis_tready_i);

  always_comb begin
    mask_pop = mask_q;
    if (load_out) begin
      mask_pop[sel] = 1'b0;
      if (is_last) begin
        mask_pop = '0;  // polynomial complete, rest of block discarded
      end
    end
  end

  assign s_axis_tready_o = (mask_pop == '0);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    cnt_d      = cnt_q;
    lo_bytes_d = lo_bytes_q;
    lo_cnt_d   = lo_cnt_q;
    mask_d     = mask_pop;
    ecnt_d     = load_out ? ecnt_q + CntW'(1) : ecnt_q;
    if (in_acc) begin
      lo_bytes_d = lo_in;
      lo_cnt_d   = lo_cnt_in;
      cnt_d      = base;
      mask_d     = '0;
      if (!full) begin
        mask_d = up.ok;
        ecnt_d = base;
        if (sum >= NumC) begin
          cnt_d      = CntW'(NUM_COEFFS);
          lo_bytes_d = 16'd0;
          lo_cnt_d   = 2'd0;
        end else begin
          cnt_d      = sum[CntW-1:0];
          lo_bytes_d = up.lo_bytes;
          lo_cnt_d   = up.lo_cnt;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= ModResetVal;
      lo_bytes_q <= '0;
      lo_cnt_q   <= '0;
      cnt_q      <= '0;
      mask_q     <= '0;
      ecnt_q     <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        modulus_q <= cfg_wdata_i;
      end
      lo_bytes_q <= lo_bytes_d;
      lo_cnt_q   <= lo_cnt_d;
      cnt_q      <= cnt_d;
      mask_q     <= mask_d;
      ecnt_q     <= ecnt_d;
      if (load_out) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cand_q <= up.cand;
    end
    if (load_out) begin
      ocoef_q <= cand_q[sel];
      oidx_q  <= IdxW'(ecnt_q);
      olast_q <= is_last;
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {4'd0, oidx_q, ocoef_q};
  assign m_axis_tlast_o  = olast_q;

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the mod-q rejection sampler: directed and random XOF blocks.
`timescale 1ns / 1ps

module testbench;
  import rsmq_pkg::*;

  localparam int unsigned NUM_COEFFS = 256;
  localparam int unsigned DRAIN_LAT  = 12;      // cycles to let an in-flight block settle
  localparam int unsigned CYCLE_CAP  = 400000;

  typedef struct {
    logic [CoefW-1:0] coefficient;
    logic [IdxW-1:0]  coeff_index;
    logic             last_coeff;
  } coef_exp_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [ModW-1:0] cfg_wdata_i;
  logic            s_axis_tvalid_i;
  logic            s_axis_tready_o;
  logic [BlkW-1:0] s_axis_tdata_i;   // [63:0] xof_block
  logic [1:0]      s_axis_tuser_i;   // [0] first_of_poly, [1] first_of_buffer
  logic            m_axis_tvalid_o;
  logic            m_axis_tready_i;
  logic [23:0]     m_axis_tdata_o;   // [11:0] coefficient, [19:12] coeff_index, 0
  logic            m_axis_tlast_o;   // last_coeff

  // sampler state mirrored by the predictor
  logic [ModW-1:0] mod_q;
  logic [15:0]     carry_bytes;
  int unsigned     carry_cnt;
  int unsigned     poly_count;

  coef_exp_t   coef_exp_q[$];
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  bit          idle_en;

  rejection_sampler_mod_q #(
    .NUM_COEFFS(NUM_COEFFS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Candidate accept: in range and polynomial not yet full.
  task automatic take_candidate(input int unsigned cand);
    coef_exp_t e;
    if (poly_count < NUM_COEFFS && cand < mod_q) begin
      e.coefficient = cand[CoefW-1:0];
      e.coeff_index = poly_count[IdxW-1:0];
      e.last_coeff  = (poly_count + 1 == NUM_COEFFS);
      coef_exp_q.push_back(e);
      poly_count++;
    end
  endtask

  task automatic predict_block(input bit poly, input bit bufst, input logic [BlkW-1:0] blk,
                               output bit dropped);
    logic [7:0]  strm [10];
    int unsigned total;
    int unsigned pos;
    int unsigned b0, b1, b2;
    total = 0;
    pos   = 0;
    if (poly) begin
      poly_count  = 0;
      carry_bytes = '0;
      carry_cnt   = 0;
    end
    if (bufst) begin
      carry_bytes = '0;
      carry_cnt   = 0;
    end
    dropped = (poly_count >= NUM_COEFFS);
    if (!dropped) begin
      for (int k = 0; k < carry_cnt; k++) strm[total++] = carry_bytes[8*k +: 8];
      for (int k = 0; k < 8; k++) strm[total++] = blk[8*(7-k) +: 8];
      while (pos + 3 <= total) begin
        b0 = strm[pos];
        b1 = strm[pos+1];
        b2 = strm[pos+2];
        pos += 3;
        take_candidate((b0 | (b1 << 8)) & 'hFFF);
        take_candidate(((b1 >> 4) | (b2 << 4)) & 'hFFF);
      end
      carry_bytes = '0;
      carry_cnt   = 0;
      // bytes after the final coefficient are thrown away
      if (poly_count < NUM_COEFFS) begin
        for (int k = 0; pos + k < total; k++) carry_bytes[8*k +: 8] = strm[pos+k];
        carry_cnt = total - pos;
      end
    end
  endtask

  // Entered and left at a falling edge.
  task automatic send_block(input bit poly, input bit bufst, input logic [BlkW-1:0] blk,
                            output bit dropped);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= blk;
    s_axis_tuser_i  <= {bufst, poly};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_block(poly, bufst, blk, dropped);
    @(negedge clk_i);
  endtask

  task automatic send_plain(input bit poly, input bit bufst, input logic [BlkW-1:0] blk);
    bit dropped;
    send_block(poly, bufst, blk, dropped);
  endtask

  // Sender holds off until every expected coefficient has left, then lets the pipe settle.
  task automatic wait_coefs_drained();
    s_axis_tvalid_i <= 1'b0;
    while (coef_exp_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_LAT) @(negedge clk_i);
  endtask

  task automatic set_modulus(input logic [ModW-1:0] q);
    wait_coefs_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= q;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    mod_q = q;
  endtask

  task automatic test_reset_modulus();
    send_plain(1'b1, 1'b0, 64'h0);                  // four zero coefficients, two bytes left
    send_plain(1'b0, 1'b1, 64'h001DD0001DD0FFFF);   // q-1 taken, q dropped
    send_plain(1'b0, 1'b0, 64'hFFFFFFFF00000000);
    send_plain(1'b0, 1'b0, 64'h0123456789ABCDEF);
    send_plain(1'b0, 1'b1, 64'hFEDCBA9876543210);
    send_plain(1'b1, 1'b1, 64'hA5A5A5A55A5A5A5A);   // both flags act as a poly start
    send_plain(1'b0, 1'b0, {$urandom, $urandom});
    send_plain(1'b0, 1'b0, {$urandom, $urandom});
  endtask

  task automatic test_modulus_extremes();
    set_modulus(13'd4096);                          // every candidate passes
    send_plain(1'b1, 1'b0, 64'hFFFFFFFFFFFFFFFF);
    send_plain(1'b0, 1'b0, {$urandom, $urandom});
    send_plain(1'b0, 1'b0, 64'hFFFFFFFFFFFFFFFF);
    set_modulus(13'd1);                             // only zero candidates pass
    send_plain(1'b1, 1'b0, 64'h0000FF000000FFFF);
    send_plain(1'b0, 1'b0, 64'h0);
    send_plain(1'b0, 1'b0, 64'h00F00F00F00F0000);
    set_modulus(13'd0);                             // nothing passes
    send_plain(1'b1, 1'b0, 64'h0);
    send_plain(1'b0, 1'b0, {$urandom, $urandom});
  endtask

  // Fill one polynomial completely, then show later blocks are ignored until a restart.
  task automatic test_full_poly();
    bit dropped;
    idle_en = 1'b1;
    set_modulus(13'd4096);
    send_block(1'b1, 1'b0, {$urandom, $urandom}, dropped);
    send_block(1'b0, 1'b1, {$urandom, $urandom}, dropped);  // shifts the group alignment
    while (poly_count < NUM_COEFFS) send_block(1'b0, 1'b0, {$urandom, $urandom}, dropped);
    repeat (3) send_block(1'b0, 1'($urandom_range(0, 1)), {$urandom, $urandom}, dropped);
    wait_coefs_drained();
    repeat (4) send_block(1'b0, 1'b0, {$urandom, $urandom}, dropped);
    send_block(1'b1, 1'b0, {$urandom, $urandom}, dropped);
    send_block(1'b0, 1'b0, {$urandom, $urandom}, dropped);
  endtask

  // Mostly whole polynomials with random content; some buffer restarts, early restarts
  // and noise blocks after completion.
  task automatic test_random_polys(input logic [ModW-1:0] q, input int unsigned n_items,
                                   input bit idling);
    int unsigned sent;
    int unsigned r;
    bit          poly;
    bit          bufst;
    bit          dropped;
    sent = 0;
    idle_en = idling;
    set_modulus(q);
    send_block(1'b1, 1'($urandom_range(0, 1)), {$urandom, $urandom}, dropped);
    while (sent < n_items) begin
      r     = $urandom_range(0, 99);
      poly  = 1'b0;
      bufst = 1'b0;
      if (poly_count >= NUM_COEFFS) begin
        poly  = (r < 60);
        bufst = 1'($urandom_range(0, 1));
      end else if (r < 3) begin
        poly  = 1'b1;
        bufst = 1'($urandom_range(0, 1));
      end else if (r < 12) begin
        bufst = 1'b1;
      end
      send_block(poly, bufst, {$urandom, $urandom}, dropped);
      if (!dropped) sent++;
      if ($urandom_range(0, 99) == 0) wait_coefs_drained();
    end
  endtask

  task automatic finish_run();
    wait_coefs_drained();
    repeat (20) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  endtask

  always @(posedge clk_i) begin
    coef_exp_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (coef_exp_q.size() == 0) begin
        $error("unexpected coefficient request: tdata=%h tlast=%b",
               m_axis_tdata_o, m_axis_tlast_o);
        fail_cnt++;
      end else begin
        e = coef_exp_q.pop_front();
        if (m_axis_tdata_o[11:0] !== e.coefficient) begin
          $error("coefficient: expected %0d, actual %0d", e.coefficient, m_axis_tdata_o[11:0]);
          fail_cnt++;
        end
        if (m_axis_tdata_o[19:12] !== e.coeff_index) begin
          $error("coeff_index: expected %0d, actual %0d", e.coeff_index, m_axis_tdata_o[19:12]);
          fail_cnt++;
        end
        if (m_axis_tdata_o[23:20] !== 4'h0) begin
          $error("tdata padding: expected 0, actual %h", m_axis_tdata_o[23:20]);
          fail_cnt++;
        end
        if (m_axis_tlast_o !== e.last_coeff) begin
          $error("last_coeff: expected %b, actual %b", e.last_coeff, m_axis_tlast_o);
          fail_cnt++;
        end
      end
    end
  end

  // Output side: random stall before each coefficient request while idling is enabled.
  initial begin : coef_sink
    int unsigned w;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      w = idle_en ? $urandom_range(0, 15) : 0;
      if (w > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    fail_cnt        = 0;
    cycle_cnt       = 0;
    idle_en         = 1'b0;
    mod_q           = ModResetVal;
    carry_bytes     = '0;
    carry_cnt       = 0;
    poly_count      = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_modulus();
    test_modulus_extremes();
    test_full_poly();
    test_random_polys(13'd3329, 150, 1'b1);
    test_random_polys(13'($urandom_range(1, 4096)), 90, 1'b1);
    test_random_polys(13'd2048, 90, 1'b0);
    test_random_polys(13'($urandom_range(1, 300)), 60, 1'b1);
    test_random_polys(13'd4096, 60, 1'b1);
    finish_run();
  end

endmodule

FILE: rejection_sampler_mod_q.f
rtl/rsmq_pkg.sv
rtl/rsmq_unpack.sv
rtl/rejection_sampler_mod_q.sv
bench/testbench.sv
